[rtl/grc_pkg.sv]
// Shared types and constants for the graph reachability closure block.
package grc_pkg;

    // Fixed field widths
    localparam int VW     = 4;   // vertex number
    localparam int CFG_W  = 5;   // vertex_count register
    localparam int EDGE_W = 9;   // edge counter

    localparam logic [CFG_W-1:0]  VCOUNT_RESET = CFG_W'(16);
    localparam logic [EDGE_W-1:0] EDGE_LIMIT   = EDGE_W'(511);

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    // Relation codes on the result
    localparam logic [1:0] REL_BOTH = 2'd0;
    localparam logic [1:0] REL_FWD  = 2'd1;
    localparam logic [1:0] REL_BWD  = 2'd2;
    localparam logic [1:0] REL_NONE = 2'd3;

    // Source of the two shared read addresses
    typedef enum logic [1:0] {
        ADDR_INPUT = 2'd0,
        ADDR_ITEM  = 2'd1,
        ADDR_SWEEP = 2'd2
    } addr_src_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;       // latch the accepted beat, zero the sweep counters
        logic      clear_adj;  // drop all adjacency rows and the edge count
        logic      ins_fwd;    // write forward entry, bump count if new
        logic      ins_rev;    // write reverse entry
        logic      copy_wr;    // write one seeded closure row
        logic      ws_start;   // zero row and pivot before the Warshall sweep
        logic      ws_wr;      // one Warshall row update, advance row/pivot
        logic      load_out;   // capture the query result
        addr_src_t addr_src;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_in_range;
        logic both;
        logic copy_last;
        logic row_last;
        logic piv_last;
        logic n_zero;
        logic out_free;
    } status_t;

endpackage

[rtl/grc_ram.sv]
// Generic simple RAM: one write port, two registered read ports.
module grc_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 16
    )
    (
        input  logic                     clk,
        input  logic                     we,
        input  logic [$clog2(DEPTH)-1:0] waddr,
        input  logic [WIDTH-1:0]         wdata,
        input  logic [$clog2(DEPTH)-1:0] raddr_a,
        input  logic [$clog2(DEPTH)-1:0] raddr_b,
        output logic [WIDTH-1:0]         rdata_a,
        output logic [WIDTH-1:0]         rdata_b
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/grc_dp.sv]
// Datapath: adjacency and closure memories, counters, config and result register.
module grc_dp
    import grc_pkg::*;
    #(
        parameter int MAX_VERTICES = 16
    )
    (
        input  logic              clk,
        input  logic              rst_n,
        input  cmd_t              cmd,
        output status_t           status,
        input  logic [VW-1:0]     in_first,
        input  logic [VW-1:0]     in_second,
        input  logic              in_both,
        input  logic              cfg_valid,
        input  logic [CFG_W-1:0]  cfg_data,
        output logic              m_tvalid,
        input  logic              m_tready,
        output logic [15:0]       m_tdata
    );

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int NB = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NB > CFG_W) ? NB : CFG_W;
    localparam logic [CW-1:0]           N_MAX = CW'(MAX_VERTICES);
    localparam logic [IW-1:0]           ROW_TOP = IW'(MAX_VERTICES - 1);
    localparam logic [MAX_VERTICES-1:0] BIT0 = MAX_VERTICES'(1);

    logic [CFG_W-1:0]        vc_reg;
    logic [VW-1:0]           a_reg, b_reg;
    logic                    both_reg;
    logic [IW-1:0]           row_reg, piv_reg;
    logic [MAX_VERTICES-1:0] adj_vld_reg, cl_vld_reg;
    logic                    adj_va_reg, adj_vb_reg, cl_va_reg, cl_vb_reg;
    logic [EDGE_W-1:0]       edge_reg;
    logic                    out_valid_reg;
    logic                    out_fwd_reg, out_bwd_reg;
    logic [1:0]              out_rel_reg;
    logic [EDGE_W-1:0]       out_cnt_reg;

    logic [CW-1:0]           n;
    logic [MAX_VERTICES-1:0] mask;
    logic [IW-1:0]           a_idx, b_idx, rd_a, rd_b;
    logic [MAX_VERTICES-1:0] adj_rd_a, adj_rd_b, cl_rd_a, cl_rd_b;
    logic [MAX_VERTICES-1:0] adj_a, adj_b, cl_a, cl_b;
    logic                    adj_we, cl_we;
    logic [IW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata, cl_wdata, copy_row;
    logic                    q_fwd, q_bwd;
    logic [1:0]              q_rel;

    // Vertices in use, limited to the built size
    assign n = (CW'(vc_reg) > N_MAX) ? N_MAX : CW'(vc_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            mask[i] = CW'(i) < n;
        end
    end

    assign a_idx = IW'(a_reg);
    assign b_idx = IW'(b_reg);

    // Shared read addresses for both memories
    always_comb
    begin
        unique case (cmd.addr_src)
            ADDR_INPUT:
            begin
                rd_a = IW'(in_first);
                rd_b = IW'(in_second);
            end
            ADDR_ITEM:
            begin
                rd_a = a_idx;
                rd_b = b_idx;
            end
            ADDR_SWEEP:
            begin
                rd_a = row_reg;
                rd_b = piv_reg;
            end
            default:
            begin
                rd_a = row_reg;
                rd_b = piv_reg;
            end
        endcase
    end

    // Adjacency rows never written since reset or clear, and closure rows never written since reset, read as zero
    assign adj_a = adj_va_reg ? adj_rd_a : '0;
    assign adj_b = adj_vb_reg ? adj_rd_b : '0;
    assign cl_a  = cl_va_reg  ? cl_rd_a  : '0;
    assign cl_b  = cl_vb_reg  ? cl_rd_b  : '0;

    // Adjacency write: forward entry at row a, reverse at row b
    assign adj_we    = cmd.ins_fwd | cmd.ins_rev;
    assign adj_waddr = cmd.ins_rev ? b_idx : a_idx;
    assign adj_wdata = cmd.ins_rev ? (adj_b | (BIT0 << a_idx)) : (adj_a | (BIT0 << b_idx));

    // Closure write: seeded row during copy, row OR pivot row during sweep when the row reaches the pivot
    assign copy_row = (CW'(row_reg) < n) ? ((adj_a & mask) | (BIT0 << row_reg)) : '0;
    assign cl_we    = cmd.copy_wr | (cmd.ws_wr & cl_a[piv_reg]);
    assign cl_wdata = cmd.copy_wr ? copy_row : (cl_a | cl_b);

    grc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram
    (
        .clk     (clk),
        .we      (adj_we),
        .waddr   (adj_waddr),
        .wdata   (adj_wdata),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (adj_rd_a),
        .rdata_b (adj_rd_b)
    );

    grc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_cl_ram
    (
        .clk     (clk),
        .we      (cl_we),
        .waddr   (row_reg),
        .wdata   (cl_wdata),
        .raddr_a (rd_a),
        .raddr_b (rd_b),
        .rdata_a (cl_rd_a),
        .rdata_b (cl_rd_b)
    );

    // Row valid bits, sampled alongside the registered reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_vld_reg <= '0;
            cl_vld_reg  <= '0;
            adj_va_reg  <= 1'b0;
            adj_vb_reg  <= 1'b0;
            cl_va_reg   <= 1'b0;
            cl_vb_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_adj)
            begin
                adj_vld_reg <= '0;
            end
            else if (adj_we)
            begin
                adj_vld_reg[adj_waddr] <= 1'b1;
            end
            if (cl_we)
            begin
                cl_vld_reg[row_reg] <= 1'b1;
            end
            adj_va_reg <= adj_vld_reg[rd_a];
            adj_vb_reg <= adj_vld_reg[rd_b];
            cl_va_reg  <= cl_vld_reg[rd_a];
            cl_vb_reg  <= cl_vld_reg[rd_b];
        end
    end

    // Config register, edge count and sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg   <= VCOUNT_RESET;
            edge_reg <= '0;
            row_reg  <= '0;
            piv_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vc_reg <= cfg_data;
            end
            if (cmd.clear_adj)
            begin
                edge_reg <= '0;
            end
            else if (cmd.ins_fwd && !adj_a[b_idx] && edge_reg != EDGE_LIMIT)
            begin
                edge_reg <= edge_reg + EDGE_W'(1);
            end
            if (cmd.load || cmd.ws_start)
            begin
                row_reg <= '0;
                piv_reg <= '0;
            end
            else if (cmd.copy_wr)
            begin
                row_reg <= row_reg + IW'(1);
            end
            else if (cmd.ws_wr)
            begin
                if (status.row_last)
                begin
                    row_reg <= '0;
                    piv_reg <= piv_reg + IW'(1);
                end
                else
                begin
                    row_reg <= row_reg + IW'(1);
                end
            end
        end
    end

    // Item fields held for the length of the operation
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg    <= in_first;
            b_reg    <= in_second;
            both_reg <= in_both;
        end
    end

    // Query result
    assign q_fwd = status.item_in_range & cl_a[b_idx];
    assign q_bwd = status.item_in_range & cl_b[a_idx];

    always_comb
    begin
        if (q_fwd && q_bwd)
        begin
            q_rel = REL_BOTH;
        end
        else if (q_fwd)
        begin
            q_rel = REL_FWD;
        end
        else if (q_bwd)
        begin
            q_rel = REL_BWD;
        end
        else
        begin
            q_rel = REL_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_fwd_reg <= q_fwd;
            out_bwd_reg <= q_bwd;
            out_rel_reg <= q_rel;
            out_cnt_reg <= edge_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_cnt_reg, out_rel_reg, out_bwd_reg, out_fwd_reg};

    // Status to the controller
    assign status.item_in_range = (CW'(a_reg) < n) && (CW'(b_reg) < n);
    assign status.both          = both_reg;
    assign status.copy_last     = row_reg == ROW_TOP;
    assign status.row_last      = (CW'(row_reg) + CW'(1)) == n;
    assign status.piv_last      = (CW'(piv_reg) + CW'(1)) == n;
    assign status.n_zero        = n == '0;
    assign status.out_free      = !out_valid_reg || m_tready;

endmodule

[rtl/grc_ctrl.sv]
// Controller: sequences insert, query, copy and Warshall sweep.
module grc_ctrl
    import grc_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  logic      s_tvalid,
        output logic      s_tready,
        input  logic [1:0] s_tuser,
        input  status_t   status,
        output cmd_t      cmd
    );

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_INS_FWD = 8'b0000_0010,
        ST_INS_REV = 8'b0000_0100,
        ST_QRY     = 8'b0000_1000,
        ST_CP_RD   = 8'b0001_0000,
        ST_CP_WR   = 8'b0010_0000,
        ST_WS_RD   = 8'b0100_0000,
        ST_WS_WR   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    op_t    op;

    assign op       = op_t'(s_tuser);
    assign s_tready = state_reg == ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_src = ADDR_ITEM;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.addr_src = ADDR_INPUT;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    unique case (op)
                        OP_CLEAR:  cmd.clear_adj = 1'b1;
                        OP_INSERT: state_next = ST_INS_FWD;
                        OP_CLOSE:  state_next = ST_CP_RD;
                        OP_QUERY:  state_next = ST_QRY;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_FWD:
            begin
                cmd.ins_fwd = status.item_in_range;
                state_next  = (status.item_in_range && status.both) ? ST_INS_REV : ST_IDLE;
            end
            ST_INS_REV:
            begin
                cmd.ins_rev = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_QRY:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CP_RD:
            begin
                cmd.addr_src = ADDR_SWEEP;
                state_next   = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                cmd.addr_src = ADDR_SWEEP;
                cmd.copy_wr  = 1'b1;
                if (status.copy_last)
                begin
                    cmd.ws_start = 1'b1;
                    state_next   = status.n_zero ? ST_IDLE : ST_WS_RD;
                end
                else
                begin
                    state_next = ST_CP_RD;
                end
            end
            ST_WS_RD:
            begin
                cmd.addr_src = ADDR_SWEEP;
                state_next   = ST_WS_WR;
            end
            ST_WS_WR:
            begin
                cmd.addr_src = ADDR_SWEEP;
                cmd.ws_wr    = 1'b1;
                state_next   = (status.row_last && status.piv_last) ? ST_IDLE : ST_WS_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/graph_reachability_closure.sv]
// Top level of the graph reachability closure block.
//
// Commands arrive on the s_ channel, one beat each; op code in s_tuser.
//   clear  : drops all edges and the edge count.
//   insert : writes the forward entry, then the reverse entry when both_ways is set.
//   close  : takes the beat, seeds the closure from the adjacency over all
//            MAX_VERTICES rows, then runs the Warshall sweep over n pivots of
//            n rows each (n = vertices in use, sweep skipped when n is 0);
//            each row update is one read, and one write when the row reaches the pivot.
//   query  : reads both closure rows as the beat is taken; the result is
//            registered onto m_ once the output register is free.
// One command is in flight at a time; s_tready is high only when idle.
// Only queries produce a result beat. A held result stays in the output
// register while m_tready is low; a following query waits for it to drain,
// other commands proceed underneath it.
// cfg_data sets vertex_count at any beat while idle; cfg_ready is always high.
// Reset leaves both matrices reading as zero, the edge count at zero and
// vertex_count at 16.
module graph_reachability_closure
    import grc_pkg::*;
    #(
        parameter int MAX_VERTICES = 16
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        s_tvalid,
        output logic        s_tready,
        input  logic [15:0] s_tdata,   // first_vertex[3:0], second_vertex[7:4], both_ways[8]
        input  logic [1:0]  s_tuser,   // operation[1:0]
        output logic        m_tvalid,
        input  logic        m_tready,
        output logic [15:0] m_tdata,   // forward_reach[0], backward_reach[1], relation[3:2],
                                       // edge_count[12:4]
        input  logic        cfg_valid,
        output logic        cfg_ready,
        input  logic [4:0]  cfg_data   // vertex_count[4:0]
    );

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    grc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    grc_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_first  (s_tdata[3:0]),
        .in_second (s_tdata[7:4]),
        .in_both   (s_tdata[8]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // result only captured into a free output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("query result loaded over an undelivered beat");

    // relation code agrees with the two reach bits
    a_rel_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[3:2] == REL_BOTH) == (m_tdata[0] && m_tdata[1])))
        else $error("relation code disagrees with reach bits");

    // any command other than clear keeps the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != OP_CLEAR) |=> !s_tready)
        else $error("block took a beat while a command was in flight");

    // reverse entry only follows a forward write
    a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_rev |-> $past(cmd.ins_fwd))
        else $error("reverse entry written without forward entry");
`endif

endmodule
